// ----- sv/ottk_pkg.sv -----
// ottk_pkg: shared constants, command and status codes and types for the
// ordered time key table. No dependencies; imported by every ottk module.
package ottk_pkg;

	// Table geometry
	localparam int DEPTH      = 64;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int RESULT_CAP = 64;

	// Field widths
	localparam int CMD_W   = 4;
	localparam int KEY_W   = 17;
	localparam int HDL_W   = 16;
	localparam int POS_W   = 6;
	localparam int COUNT_W = 7;
	localparam int ST_W    = 2;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PUT      = 4'd0;
	localparam logic [CMD_W-1:0] CMD_GET      = 4'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE   = 4'd2;
	localparam logic [CMD_W-1:0] CMD_CONTAINS = 4'd3;
	localparam logic [CMD_W-1:0] CMD_MIN      = 4'd4;
	localparam logic [CMD_W-1:0] CMD_MAX      = 4'd5;
	localparam logic [CMD_W-1:0] CMD_FLOOR    = 4'd6;
	localparam logic [CMD_W-1:0] CMD_CEIL     = 4'd7;
	localparam logic [CMD_W-1:0] CMD_RANK     = 4'd8;
	localparam logic [CMD_W-1:0] CMD_SELECT   = 4'd9;
	localparam logic [CMD_W-1:0] CMD_DELMIN   = 4'd10;
	localparam logic [CMD_W-1:0] CMD_DELMAX   = 4'd11;
	localparam logic [CMD_W-1:0] CMD_SIZE     = 4'd12;
	localparam logic [CMD_W-1:0] CMD_SRANGE   = 4'd13;
	localparam logic [CMD_W-1:0] CMD_KEYS     = 4'd14;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_NONE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;

	// Result of the shared key comparator
	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_t;

	// Clamp an internal count to the result count field
	function automatic logic [COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] x);
		if (32'(x) > 32'd127)
			return 7'd127;
		else
			return COUNT_W'(x);
	endfunction

endpackage

// ----- sv/ottk_store.sv -----
// ottk_store: key and handle memories of the table, one write port and one
// read port with registered read data. Depends on ottk_pkg.
module ottk_store import ottk_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [KEY_W-1:0] wkey,
	input  logic [HDL_W-1:0] whdl,
	input  logic [IDX_W-1:0] raddr,
	output logic [KEY_W-1:0] rkey,
	output logic [HDL_W-1:0] rhdl
);

	logic [KEY_W-1:0] key_mem [DEPTH];
	logic [HDL_W-1:0] hdl_mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
			hdl_mem[waddr] <= whdl;
		end
		rkey <= key_mem[raddr];
		rhdl <= hdl_mem[raddr];
	end

endmodule

// ----- sv/ottk_cmp.sv -----
// ottk_cmp: the one key comparator shared by every step of the sequencer.
// Depends on ottk_pkg.
module ottk_cmp import ottk_pkg::*; (
	input  logic [KEY_W-1:0] a,
	input  logic [KEY_W-1:0] b,
	output cmp_t             res
);

	// Unsigned magnitude compare
	assign res.lt = (a < b);
	assign res.eq = (a == b);

endmodule

// ----- sv/ordered_time_key_table_unit.sv -----
// ordered_time_key_table_unit: sorted key/handle table with a small
// sequencer over one two-port memory and one comparator.
// Depends on ottk_pkg, ottk_store, ottk_cmp.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------------------
//  command | cmd_valid | cmd_stall | command, key, key_high, value_handle, position
//  result  | res_valid | res_stall | key_out, value_out, count_out, status, last
//
// Every command first scans the table from the bottom, comparing each key
// below the search key in turn, then does its own work: insert and delete
// move one entry at a time with a read and a write, and range walks read
// and compare one entry at a time. The longest transaction is a delmin
// whose key lies above every entry of a full table, as all steps share the
// single memory read port. cmd_stall stays high from acceptance until the
// last result is loaded. A stalled result holds the sequencer. Reset
// empties the table at once; no clearing pass is needed.
module ordered_time_key_table_unit import ottk_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [CMD_W-1:0]   command,
	input  logic [KEY_W-1:0]   key,
	input  logic [KEY_W-1:0]   key_high,
	input  logic [HDL_W-1:0]   value_handle,
	input  logic [POS_W-1:0]   position,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [KEY_W-1:0]   key_out,
	output logic [HDL_W-1:0]   value_out,
	output logic [COUNT_W-1:0] count_out,
	output logic [ST_W-1:0]    status,
	output logic               last
);

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [HDL_W-1:0]   value;
		logic [COUNT_W-1:0] count;
		logic [ST_W-1:0]    status;
		logic               last;
	} res_t;

	// Sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SRD    = 4'd1;
	localparam logic [3:0] S_SCMP   = 4'd2;
	localparam logic [3:0] S_EXEC   = 4'd3;
	localparam logic [3:0] S_RD1    = 4'd4;
	localparam logic [3:0] S_FIN1   = 4'd5;
	localparam logic [3:0] S_INS_RD = 4'd6;
	localparam logic [3:0] S_INS_WR = 4'd7;
	localparam logic [3:0] S_DEL_RD = 4'd8;
	localparam logic [3:0] S_DEL_WR = 4'd9;
	localparam logic [3:0] S_WRD    = 4'd10;
	localparam logic [3:0] S_WCMP   = 4'd11;
	localparam logic [3:0] S_WEND   = 4'd12;

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] j_q, j_d;
	logic [CNT_W-1:0] m_q, m_d;
	logic [IDX_W-1:0] addr_q, addr_d;
	logic             found_q, found_d;
	logic [KEY_W-1:0] hit_key_q, hit_key_d;
	logic [HDL_W-1:0] hit_hdl_q, hit_hdl_d;
	logic [KEY_W-1:0] res_key_q, res_key_d;
	logic [CNT_W-1:0] rcnt_q, rcnt_d;
	logic [CNT_W-1:0] emitted_q, emitted_d;
	logic             pend_q, pend_d;
	logic [KEY_W-1:0] pend_key_q, pend_key_d;

	logic [CMD_W-1:0] cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] khi_q;
	logic [HDL_W-1:0] hdl_q;
	logic [POS_W-1:0] pos_q;

	res_t res_q, res_d;
	logic res_valid_q;
	logic emit, out_free, accept;

	logic             we;
	logic [IDX_W-1:0] waddr, raddr;
	logic [KEY_W-1:0] wkey, rd_key, cmp_a, cmp_b;
	logic [HDL_W-1:0] whdl, rd_hdl;
	cmp_t             cmp;

	ottk_store u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wkey  (wkey),
		.whdl  (whdl),
		.raddr (raddr),
		.rkey  (rd_key),
		.rhdl  (rd_hdl)
	);

	ottk_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp)
	);

	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign out_free  = !res_valid_q || !res_stall;

	// Read address: held stable in states that may wait on the result side
	always_comb begin
		unique case (state_q)
			S_SRD, S_SCMP, S_WRD, S_WCMP: raddr = j_q[IDX_W-1:0];
			S_INS_RD:                     raddr = IDX_W'(m_q - CNT_W'(1));
			S_DEL_RD:                     raddr = IDX_W'(m_q + CNT_W'(1));
			default:                      raddr = addr_q;
		endcase
	end

	// Comparator operands
	always_comb begin
		unique case (state_q)
			S_EXEC: begin
				cmp_a = key_q;
				cmp_b = khi_q;
			end
			S_WCMP: begin
				cmp_a = rd_key;
				cmp_b = khi_q;
			end
			default: begin
				cmp_a = rd_key;
				cmp_b = key_q;
			end
		endcase
	end

	// Sequencer
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		j_d        = j_q;
		m_d        = m_q;
		addr_d     = addr_q;
		found_d    = found_q;
		hit_key_d  = hit_key_q;
		hit_hdl_d  = hit_hdl_q;
		res_key_d  = res_key_q;
		rcnt_d     = rcnt_q;
		emitted_d  = emitted_q;
		pend_d     = pend_q;
		pend_key_d = pend_key_q;
		emit       = 1'b0;
		res_d      = '0;
		res_d.last = 1'b1;
		we         = 1'b0;
		waddr      = j_q[IDX_W-1:0];
		wkey       = key_q;
		whdl       = hdl_q;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					j_d     = '0;
					state_d = S_SRD;
				end
			end

			// lower-bound scan: first entry whose key is not below the key
			S_SRD: begin
				if (j_q == cnt_q) begin
					found_d = 1'b0;
					state_d = S_EXEC;
				end else begin
					state_d = S_SCMP;
				end
			end

			S_SCMP: begin
				if (cmp.lt) begin
					j_d     = j_q + CNT_W'(1);
					state_d = S_SRD;
				end else begin
					found_d   = cmp.eq;
					hit_key_d = rd_key;
					hit_hdl_d = rd_hdl;
					state_d   = S_EXEC;
				end
			end

			S_EXEC: begin
				unique case (cmd_q)
					CMD_PUT, CMD_DELETE: begin
						if (cmd_q == CMD_PUT && hdl_q != '0) begin
							if (found_q) begin
								we        = 1'b1;
								emit      = 1'b1;
								res_d.key = key_q;
								state_d   = S_IDLE;
							end else if (32'(cnt_q) >= DEPTH) begin
								emit         = 1'b1;
								res_d.status = ST_FULL;
								state_d      = S_IDLE;
							end else begin
								m_d     = cnt_q;
								state_d = S_INS_RD;
							end
						end else if (found_q) begin
							res_key_d = key_q;
							m_d       = j_q;
							state_d   = S_DEL_RD;
						end else begin
							emit         = 1'b1;
							res_d.status = ST_NONE;
							state_d      = S_IDLE;
						end
					end
					CMD_GET: begin
						emit    = 1'b1;
						state_d = S_IDLE;
						if (found_q) begin
							res_d.key   = key_q;
							res_d.value = hit_hdl_q;
						end else begin
							res_d.status = ST_NONE;
						end
					end
					CMD_CONTAINS: begin
						emit    = 1'b1;
						state_d = S_IDLE;
						if (found_q)
							res_d.key = key_q;
						else
							res_d.status = ST_NONE;
					end
					CMD_MIN, CMD_DELMIN: begin
						if (cnt_q == '0) begin
							emit         = 1'b1;
							res_d.status = ST_NONE;
							state_d      = S_IDLE;
						end else begin
							addr_d  = '0;
							state_d = S_RD1;
						end
					end
					CMD_MAX, CMD_DELMAX: begin
						if (cnt_q == '0) begin
							emit         = 1'b1;
							res_d.status = ST_NONE;
							state_d      = S_IDLE;
						end else begin
							addr_d  = IDX_W'(cnt_q - CNT_W'(1));
							state_d = S_RD1;
						end
					end
					CMD_FLOOR: begin
						if (found_q) begin
							emit      = 1'b1;
							res_d.key = key_q;
							state_d   = S_IDLE;
						end else if (j_q != '0) begin
							addr_d  = IDX_W'(j_q - CNT_W'(1));
							state_d = S_RD1;
						end else begin
							emit         = 1'b1;
							res_d.status = ST_NONE;
							state_d      = S_IDLE;
						end
					end
					CMD_CEIL: begin
						emit    = 1'b1;
						state_d = S_IDLE;
						if (j_q < cnt_q)
							res_d.key = hit_key_q;
						else
							res_d.status = ST_NONE;
					end
					CMD_RANK: begin
						emit        = 1'b1;
						res_d.count = sat_count(j_q);
						state_d     = S_IDLE;
					end
					CMD_SELECT: begin
						if (32'(pos_q) < 32'(cnt_q)) begin
							addr_d  = IDX_W'(pos_q);
							state_d = S_RD1;
						end else begin
							emit         = 1'b1;
							res_d.status = ST_NONE;
							state_d      = S_IDLE;
						end
					end
					CMD_SIZE: begin
						emit        = 1'b1;
						res_d.count = sat_count(cnt_q);
						state_d     = S_IDLE;
					end
					CMD_SRANGE, CMD_KEYS: begin
						// empty range when low bound is not below high bound
						if (!cmp.lt) begin
							emit    = 1'b1;
							state_d = S_IDLE;
							if (cmd_q == CMD_KEYS)
								res_d.status = ST_NONE;
						end else begin
							j_d       = found_q ? j_q + CNT_W'(1) : j_q;
							rcnt_d    = '0;
							emitted_d = '0;
							pend_d    = 1'b0;
							state_d   = S_WRD;
						end
					end
					default: begin
						emit         = 1'b1;
						res_d.status = ST_NONE;
						state_d      = S_IDLE;
					end
				endcase
			end

			S_RD1: begin
				state_d = S_FIN1;
			end

			S_FIN1: begin
				if (cmd_q == CMD_DELMIN) begin
					res_key_d = rd_key;
					m_d       = '0;
					state_d   = S_DEL_RD;
				end else begin
					emit      = 1'b1;
					res_d.key = rd_key;
					state_d   = S_IDLE;
					if (cmd_q == CMD_DELMAX)
						cnt_d = cnt_q - CNT_W'(1);
				end
			end

			// insert: move entries up from the top down to the hole
			S_INS_RD: begin
				if (m_q == j_q) begin
					we        = 1'b1;
					cnt_d     = cnt_q + CNT_W'(1);
					emit      = 1'b1;
					res_d.key = key_q;
					state_d   = S_IDLE;
				end else begin
					state_d = S_INS_WR;
				end
			end

			S_INS_WR: begin
				we      = 1'b1;
				waddr   = m_q[IDX_W-1:0];
				wkey    = rd_key;
				whdl    = rd_hdl;
				m_d     = m_q - CNT_W'(1);
				state_d = S_INS_RD;
			end

			// delete: move entries down over the removed one
			S_DEL_RD: begin
				if (m_q + CNT_W'(1) == cnt_q) begin
					cnt_d     = cnt_q - CNT_W'(1);
					emit      = 1'b1;
					res_d.key = res_key_q;
					state_d   = S_IDLE;
				end else begin
					state_d = S_DEL_WR;
				end
			end

			S_DEL_WR: begin
				we      = 1'b1;
				waddr   = m_q[IDX_W-1:0];
				wkey    = rd_key;
				whdl    = rd_hdl;
				m_d     = m_q + CNT_W'(1);
				state_d = S_DEL_RD;
			end

			// range walk; one key is held back so the last one can be marked
			S_WRD: begin
				if (j_q == cnt_q ||
				    (cmd_q == CMD_KEYS && pend_q && 32'(emitted_q) == RESULT_CAP - 1))
					state_d = S_WEND;
				else
					state_d = S_WCMP;
			end

			S_WCMP: begin
				if (!cmp.lt) begin
					state_d = S_WEND;
				end else begin
					rcnt_d  = rcnt_q + CNT_W'(1);
					j_d     = j_q + CNT_W'(1);
					state_d = S_WRD;
					if (cmd_q == CMD_KEYS) begin
						pend_d     = 1'b1;
						pend_key_d = rd_key;
						if (pend_q) begin
							emit       = 1'b1;
							res_d.key  = pend_key_q;
							res_d.last = 1'b0;
							emitted_d  = emitted_q + CNT_W'(1);
						end
					end
				end
			end

			S_WEND: begin
				emit    = 1'b1;
				state_d = S_IDLE;
				if (cmd_q == CMD_SRANGE)
					res_d.count = sat_count(rcnt_q);
				else if (pend_q)
					res_d.key = pend_key_q;
				else
					res_d.status = ST_NONE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		// result slot busy: freeze the sequencer
		if (emit && !out_free) begin
			state_d    = state_q;
			cnt_d      = cnt_q;
			j_d        = j_q;
			m_d        = m_q;
			rcnt_d     = rcnt_q;
			emitted_d  = emitted_q;
			pend_d     = pend_q;
			pend_key_d = pend_key_q;
			we         = 1'b0;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (emit && out_free)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	// Working and payload registers
	always_ff @(posedge clk) begin
		j_q        <= j_d;
		m_q        <= m_d;
		addr_q     <= addr_d;
		found_q    <= found_d;
		hit_key_q  <= hit_key_d;
		hit_hdl_q  <= hit_hdl_d;
		res_key_q  <= res_key_d;
		rcnt_q     <= rcnt_d;
		emitted_q  <= emitted_d;
		pend_q     <= pend_d;
		pend_key_q <= pend_key_d;
		if (accept) begin
			cmd_q <= command;
			key_q <= key;
			khi_q <= key_high;
			hdl_q <= value_handle;
			pos_q <= position;
		end
		if (emit && out_free)
			res_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign key_out   = res_q.key;
	assign value_out = res_q.value;
	assign count_out = res_q.count;
	assign status    = res_q.status;
	assign last      = res_q.last;

	// Entry count never exceeds the table depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= DEPTH)
		else $error("entry count above depth");

	// Entry count moves by at most one per cycle
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + CNT_W'(1) ||
		cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("entry count jumped");

	// An accepted transaction makes the block busy in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> cmd_stall)
		else $error("not busy after accept");

	// The table is written only while a command is in progress
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> cmd_stall)
		else $error("table write while idle");

endmodule

// ----- dv/ottk_table_checker.sv -----
// ottk_table_checker: passive checker for ordered_time_key_table_unit. It keeps its own
// sorted key/handle table, predicts the results of each accepted command and compares them.
// Depends on ottk_pkg for widths, command and status codes.
module ottk_table_checker import ottk_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_stall,
	input  logic [CMD_W-1:0]   command,
	input  logic [KEY_W-1:0]   key,
	input  logic [KEY_W-1:0]   key_high,
	input  logic [HDL_W-1:0]   value_handle,
	input  logic [POS_W-1:0]   position,
	input  logic               res_valid,
	input  logic               res_stall,
	input  logic [KEY_W-1:0]   key_out,
	input  logic [HDL_W-1:0]   value_out,
	input  logic [COUNT_W-1:0] count_out,
	input  logic [ST_W-1:0]    status,
	input  logic               last,
	output int                 mismatches,
	output int                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [HDL_W-1:0]   handle;
		logic [COUNT_W-1:0] count;
		logic [ST_W-1:0]    st;
		logic               fin;
	} table_answer_t;

	// Shadow table: keys ascending in table_key[0 .. live_count-1]
	logic [KEY_W-1:0] table_key [DEPTH];
	logic [HDL_W-1:0] table_hdl [DEPTH];
	int               live_count;

	table_answer_t answers_q [$];
	int            results_seen;

	// One line per mismatch
	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		$display("%0t ottk_table_checker: result %0d %s: got %0d, expected %0d",
			$realtime, results_seen, what, got, want);
	endtask

	task automatic expect_answer(input logic [KEY_W-1:0] k, input logic [HDL_W-1:0] h,
		input logic [COUNT_W-1:0] cnt, input logic [ST_W-1:0] st, input logic fin);
		answers_q.push_back('{key: k, handle: h, count: cnt, st: st, fin: fin});
	endtask

	task automatic drop_entry(input int idx);
		for (int j = idx; j < live_count - 1; j++) begin
			table_key[j] = table_key[j + 1];
			table_hdl[j] = table_hdl[j + 1];
		end
		live_count--;
	endtask

	// Apply one command to the shadow table and queue the results it yields
	task automatic step_table(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] k,
		input logic [KEY_W-1:0] k_hi, input logic [HDL_W-1:0] hdl,
		input logic [POS_W-1:0] pos);
		int  idx;
		int  n;
		int  first;
		int  in_range;
		int  shown;
		bit  hit;
		n = live_count;
		idx = 0;
		while (idx < n && table_key[idx] < k)
			idx++;
		hit = (idx < n) && (table_key[idx] == k);
		case (op)
			CMD_PUT, CMD_DELETE: begin
				if (op == CMD_PUT && hdl != '0) begin
					if (hit) begin
						table_hdl[idx] = hdl;
						expect_answer(k, '0, '0, ST_OK, 1'b1);
					end else if (n >= DEPTH) begin
						expect_answer('0, '0, '0, ST_FULL, 1'b1);
					end else begin
						for (int j = n; j > idx; j--) begin
							table_key[j] = table_key[j - 1];
							table_hdl[j] = table_hdl[j - 1];
						end
						table_key[idx] = k;
						table_hdl[idx] = hdl;
						live_count++;
						expect_answer(k, '0, '0, ST_OK, 1'b1);
					end
				end else begin
					// zero handle on put removes the key, same as delete
					if (hit)
						drop_entry(idx);
					expect_answer(hit ? k : '0, '0, '0, hit ? ST_OK : ST_NONE, 1'b1);
				end
			end
			CMD_GET: begin
				expect_answer(hit ? k : '0, hit ? table_hdl[idx] : '0, '0,
					hit ? ST_OK : ST_NONE, 1'b1);
			end
			CMD_CONTAINS: begin
				expect_answer(hit ? k : '0, '0, '0, hit ? ST_OK : ST_NONE, 1'b1);
			end
			CMD_MIN: begin
				expect_answer(n > 0 ? table_key[0] : '0, '0, '0, n > 0 ? ST_OK : ST_NONE, 1'b1);
			end
			CMD_MAX: begin
				expect_answer(n > 0 ? table_key[n - 1] : '0, '0, '0,
					n > 0 ? ST_OK : ST_NONE, 1'b1);
			end
			CMD_FLOOR: begin
				if (hit)
					expect_answer(k, '0, '0, ST_OK, 1'b1);
				else if (idx > 0)
					expect_answer(table_key[idx - 1], '0, '0, ST_OK, 1'b1);
				else
					expect_answer('0, '0, '0, ST_NONE, 1'b1);
			end
			CMD_CEIL: begin
				expect_answer(idx < n ? table_key[idx] : '0, '0, '0,
					idx < n ? ST_OK : ST_NONE, 1'b1);
			end
			CMD_RANK: begin
				expect_answer('0, '0, COUNT_W'(idx), ST_OK, 1'b1);
			end
			CMD_SELECT: begin
				expect_answer(int'(pos) < n ? table_key[pos] : '0, '0, '0,
					int'(pos) < n ? ST_OK : ST_NONE, 1'b1);
			end
			CMD_DELMIN: begin
				if (n == 0) begin
					expect_answer('0, '0, '0, ST_NONE, 1'b1);
				end else begin
					expect_answer(table_key[0], '0, '0, ST_OK, 1'b1);
					drop_entry(0);
				end
			end
			CMD_DELMAX: begin
				if (n == 0) begin
					expect_answer('0, '0, '0, ST_NONE, 1'b1);
				end else begin
					expect_answer(table_key[n - 1], '0, '0, ST_OK, 1'b1);
					drop_entry(n - 1);
				end
			end
			CMD_SIZE: begin
				expect_answer('0, '0, COUNT_W'(n), ST_OK, 1'b1);
			end
			CMD_SRANGE, CMD_KEYS: begin
				// keys strictly between the bounds; an inverted range is empty
				first = hit ? idx + 1 : idx;
				in_range = 0;
				if (k < k_hi) begin
					while (first + in_range < n && table_key[first + in_range] < k_hi)
						in_range++;
				end
				if (op == CMD_SRANGE) begin
					expect_answer('0, '0, COUNT_W'(in_range), ST_OK, 1'b1);
				end else if (in_range == 0) begin
					expect_answer('0, '0, '0, ST_NONE, 1'b1);
				end else begin
					shown = (in_range > RESULT_CAP) ? RESULT_CAP : in_range;
					for (int j = 0; j < shown; j++)
						expect_answer(table_key[first + j], '0, '0, ST_OK, j == shown - 1);
				end
			end
			default: begin
				expect_answer('0, '0, '0, ST_NONE, 1'b1);
			end
		endcase
	endtask

	// Results are checked before the command of the same edge is applied
	always @(posedge clk or negedge arst_n) begin
		table_answer_t want;
		if (!arst_n) begin
			live_count = 0;
			answers_q.delete();
			outstanding = 0;
			mismatches = 0;
			results_seen = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (answers_q.size() == 0) begin
					report_mismatch("arrived with nothing expected, key_out", key_out, 0);
				end else begin
					want = answers_q.pop_front();
					if (key_out !== want.key)
						report_mismatch("key_out", key_out, want.key);
					if (value_out !== want.handle)
						report_mismatch("value_out", value_out, want.handle);
					if (count_out !== want.count)
						report_mismatch("count_out", count_out, want.count);
					if (status !== want.st)
						report_mismatch("status", status, want.st);
					if (last !== want.fin)
						report_mismatch("last", last, want.fin);
				end
				results_seen++;
			end
			if (cmd_valid && !cmd_stall)
				step_table(command, key, key_high, value_handle, position);
			outstanding = answers_q.size();
		end
	end

endmodule

// ----- dv/tb_ordered_time_key_table_unit.sv -----
// tb_ordered_time_key_table_unit: stimulus and verdict for ordered_time_key_table_unit.
// Drives directed and random command transactions with random idling on both channels.
// Depends on ottk_pkg, the block itself and ottk_table_checker.
module tb_ordered_time_key_table_unit import ottk_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam real              HALF_PERIOD  = 6.0;
	localparam int               RESET_CYCLES = 12;
	localparam int               LONG_HOLD    = 400;
	localparam int               DRAIN_LIMIT  = 20000;
	localparam int               SETTLE       = 30;
	localparam int               PHASE_ITEMS  = 85;
	localparam logic [KEY_W-1:0] MAX_KEY      = 17'd86399;
	localparam logic [CMD_W-1:0] CMD_UNUSED   = 4'd15;
	localparam int               N_QUERY_OPS  = 14;
	localparam logic [CMD_W-1:0] QUERY_OPS [N_QUERY_OPS] = '{
		CMD_GET, CMD_DELETE, CMD_CONTAINS, CMD_MIN, CMD_MAX, CMD_FLOOR, CMD_CEIL,
		CMD_RANK, CMD_SELECT, CMD_DELMIN, CMD_DELMAX, CMD_SIZE, CMD_SRANGE, CMD_KEYS
	};

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cmd_valid    = 1'b0;
	logic               cmd_stall;
	logic [CMD_W-1:0]   command      = '0;
	logic [KEY_W-1:0]   key          = '0;
	logic [KEY_W-1:0]   key_high     = '0;
	logic [HDL_W-1:0]   value_handle = '0;
	logic [POS_W-1:0]   position     = '0;
	logic               res_valid;
	logic               res_stall    = 1'b0;
	logic [KEY_W-1:0]   key_out;
	logic [HDL_W-1:0]   value_out;
	logic [COUNT_W-1:0] count_out;
	logic [ST_W-1:0]    status;
	logic               last;

	int mismatches;
	int outstanding;
	int sender_gap_pct   = 23;
	int receiver_gap_pct = 45;
	bit hold_off_req     = 1'b0;

	// keys that were put, reused so lookups and deletes hit
	logic [KEY_W-1:0] used_keys [$];

	always #HALF_PERIOD clk = ~clk;

	ordered_time_key_table_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.command      (command),
		.key          (key),
		.key_high     (key_high),
		.value_handle (value_handle),
		.position     (position),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.key_out      (key_out),
		.value_out    (value_out),
		.count_out    (count_out),
		.status       (status),
		.last         (last)
	);

	ottk_table_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.command      (command),
		.key          (key),
		.key_high     (key_high),
		.value_handle (value_handle),
		.position     (position),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.key_out      (key_out),
		.value_out    (value_out),
		.count_out    (count_out),
		.status       (status),
		.last         (last),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// Offer one command transaction after a random gap; returns at the accepting edge
	task automatic issue_command(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] k,
		input logic [KEY_W-1:0] k_hi, input logic [HDL_W-1:0] hdl,
		input logic [POS_W-1:0] pos);
		while ($urandom_range(99) < sender_gap_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid    <= 1'b1;
		command      <= op;
		key          <= k;
		key_high     <= k_hi;
		value_handle <= hdl;
		position     <= pos;
		do
			@(posedge clk);
		while (cmd_stall);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		int               r;
		logic [KEY_W-1:0] k;
		r = $urandom_range(99);
		if (used_keys.size() == 0 || r >= 60)
			k = KEY_W'($urandom_range(MAX_KEY));
		else
			k = used_keys[$urandom_range(used_keys.size() - 1)];
		// neighbors of stored keys land floor and ceiling between entries
		if (r < 15)
			k = k + 1'b1;
		else if (r < 25)
			k = k - 1'b1;
		else if (r == 95)
			k = '0;
		else if (r == 96)
			k = MAX_KEY;
		else if (r == 97)
			k = '1;
		return k;
	endfunction

	task automatic random_command(input int put_pct);
		logic [CMD_W-1:0] op;
		logic [KEY_W-1:0] lo;
		logic [KEY_W-1:0] hi;
		logic [KEY_W-1:0] swap;
		logic [HDL_W-1:0] hdl;
		logic [POS_W-1:0] pos;
		lo = pick_key();
		hi = pick_key();
		// mostly proper ranges, some inverted ones
		if (hi < lo && $urandom_range(3) != 0) begin
			swap = lo;
			lo = hi;
			hi = swap;
		end
		hdl = ($urandom_range(19) == 0) ? '0 : HDL_W'($urandom_range(16'hFFFF, 1));
		pos = ($urandom_range(1) == 0) ? POS_W'($urandom_range(15)) : POS_W'($urandom_range(63));
		if ($urandom_range(99) < put_pct)
			op = CMD_PUT;
		else if ($urandom_range(39) == 0)
			op = CMD_UNUSED;
		else
			op = QUERY_OPS[$urandom_range(N_QUERY_OPS - 1)];
		if (op == CMD_PUT && hdl != '0) begin
			used_keys.push_back(lo);
			if (used_keys.size() > 64)
				void'(used_keys.pop_front());
		end
		issue_command(op, lo, hi, hdl, pos);
	endtask

	// Result side: random stall, plus one long hold-off on request
	initial begin : result_side
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_done) begin
				hold_done = 1'b1;
				repeat (LONG_HOLD) begin
					res_stall <= 1'b1;
					@(posedge clk);
				end
			end else begin
				res_stall <= ($urandom_range(99) < receiver_gap_pct);
			end
		end
	end

	initial begin : stimulus
		int guard;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table corners
		issue_command(CMD_MIN,    '0, '0, '0, '0);
		issue_command(CMD_DELMAX, '0, '0, '0, '0);
		issue_command(CMD_KEYS,   '0, '1, '0, '0);
		issue_command(CMD_SELECT, '0, '0, '0, '0);
		// Extreme keys and handles, a key above one day, a replacing put
		issue_command(CMD_PUT, '0,          '0, 16'hFFFF, '0);
		issue_command(CMD_PUT, MAX_KEY,     '0, 16'h0001, '0);
		issue_command(CMD_PUT, '1,          '0, 16'h8000, '0);
		issue_command(CMD_PUT, 17'd43200,   '0, 16'h5555, '0);
		issue_command(CMD_PUT, 17'd43200,   '0, 16'hAAAA, '0);
		// Lookups on the small table
		issue_command(CMD_GET,      17'd43200, '0, '0, '0);
		issue_command(CMD_GET,      17'd43201, '0, '0, '0);
		issue_command(CMD_CONTAINS, MAX_KEY,   '0, '0, '0);
		issue_command(CMD_FLOOR,    17'd43199, '0, '0, '0);
		issue_command(CMD_CEIL,     17'd86400, '0, '0, '0);
		issue_command(CMD_RANK,     MAX_KEY,   '0, '0, '0);
		issue_command(CMD_SELECT,   '0,        '0, '0, '1);
		issue_command(CMD_SRANGE,   '0,        '1, '0, '0);
		issue_command(CMD_KEYS,     '0,        '1, '0, '0);
		issue_command(CMD_KEYS,     MAX_KEY,   '0, '0, '0);
		issue_command(CMD_SIZE,     '0,        '0, '0, '0);
		// Deletion paths: zero-handle put, missing key, unused code, both ends
		issue_command(CMD_PUT,    17'd43200, '0, '0, '0);
		issue_command(CMD_DELETE, 17'd5,     '0, '0, '0);
		issue_command(CMD_UNUSED, '1,        '1, 16'hFFFF, '1);
		issue_command(CMD_DELMAX, '0,        '0, '0, '0);
		issue_command(CMD_DELMIN, '0,        '0, '0, '0);

		// Sender idles less than receiver; one long result hold-off early on
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i == 20)
				hold_off_req = 1'b1;
			random_command(40);
		end

		// Roles swapped; a burst of puts fills the table past full
		sender_gap_pct   = 45;
		receiver_gap_pct = 23;
		for (int i = 0; i < PHASE_ITEMS; i++)
			random_command(i < 70 ? 90 : 35);

		// No idling on either side
		sender_gap_pct   = 0;
		receiver_gap_pct = 0;
		for (int i = 0; i < PHASE_ITEMS; i++)
			random_command(30);
		cmd_valid <= 1'b0;

		guard = 0;
		while (outstanding != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("tb_ordered_time_key_table_unit: clean");
		else
			$display("tb_ordered_time_key_table_unit: errors");
		$finish;
	end

	// Hang guard
	initial begin : watchdog
		#20ms;
		$display("tb_ordered_time_key_table_unit: errors");
		$finish;
	end

endmodule
